// ===== rtl/core/phmm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pixel histogram block: shared constants, operation codes
// and the payload and work-queue item types. No dependencies.
package phmm_pkg;

    localparam int NUM_BINS_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 24;

    // Widest bin address and pixel that the parameter ranges allow
    localparam int MAX_BIN_BITS   = 16;
    localparam int MAX_PIXEL_BITS = 32;

    localparam int QUEUE_DEPTH    = 4;
    // Folding passes that reduce pixel*(bins-1) modulo the all-ones pixel
    localparam int FOLD_STEPS     = 4;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD   = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    typedef struct packed {
        t_op         operation;
        logic [15:0] pixel;
        logic [9:0]  bin_index;
    } t_in_item;

    typedef struct packed {
        logic [23:0] bin_count;
        logic [15:0] min_pixel;
        logic [15:0] max_pixel;
        logic [23:0] peak_count;
    } t_out_item;

    // Classified item handed from the front to the back
    typedef struct packed {
        t_op                       op;
        logic                      in_range;
        logic [MAX_BIN_BITS-1:0]   bin;
        logic [MAX_PIXEL_BITS-1:0] pixel;
    } t_work;

endpackage

// ===== rtl/core/phmm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module phmm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/phmm_queue.sv =====
`timescale 1ns / 1ps
// Short flop-based FIFO between the front and the back of the histogram.
// Depends on phmm_pkg for the default depth.
module phmm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = phmm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/phmm_front.sv =====
`timescale 1ns / 1ps
// Front of the histogram: accepts items, maps each pixel to its bin and
// checks read indexes, then queues the classified item. Depends on phmm_pkg.
module phmm_front #(
    parameter int NUM_BINS   = phmm_pkg::NUM_BINS_DEF,
    parameter int PIXEL_BITS = phmm_pkg::PIXEL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  phmm_pkg::t_in_item i_item,
    input  logic               i_hold,
    output logic               o_q_push,
    output phmm_pkg::t_work    o_q_data,
    input  logic               i_q_full
);

    import phmm_pkg::*;

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam int XW       = PIXEL_BITS + BIN_BITS;
    localparam logic [XW-1:0] PIX_MAX = {{BIN_BITS{1'b0}}, {PIXEL_BITS{1'b1}}};
    localparam logic [XW-1:0] BIN_TOP = XW'(NUM_BINS - 1);

    logic                  accept;
    logic [PIXEL_BITS-1:0] px_in;
    logic                  r_v;
    t_in_item              r_item;
    logic [XW-1:0]         r_prod;
    logic [XW-1:0]         quot;
    logic [XW-1:0]         bin_q;

    assign px_in    = PIXEL_BITS'(i_item.pixel);
    assign o_full   = i_hold || (r_v && i_q_full);
    assign accept   = i_push && !o_full;
    assign o_q_push = r_v && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (!i_q_full) begin
            r_v <= 1'b0;
        end
        if (accept) begin
            r_item <= i_item;
            r_prod <= XW'(px_in) * BIN_TOP;
        end
    end

    // Divide by 2^P-1: fold the high part onto the low part, then correct once
    always_comb begin
        logic [XW-1:0] y;
        logic [XW-1:0] q;
        y = r_prod;
        q = '0;
        for (int k = 0; k < FOLD_STEPS; k++) begin
            q = q + (y >> PIXEL_BITS);
            y = (y & PIX_MAX) + (y >> PIXEL_BITS);
        end
        if (y >= PIX_MAX) begin
            q = q + 1'b1;
        end
        quot = q;
    end

    assign bin_q = (quot > BIN_TOP) ? BIN_TOP : quot;

    always_comb begin
        o_q_data.op    = r_item.operation;
        o_q_data.pixel = MAX_PIXEL_BITS'(PIXEL_BITS'(r_item.pixel));
        if (r_item.operation == OP_ADD) begin
            o_q_data.bin      = MAX_BIN_BITS'(bin_q);
            o_q_data.in_range = 1'b1;
        end else begin
            o_q_data.bin      = MAX_BIN_BITS'(r_item.bin_index);
            o_q_data.in_range = (32'(r_item.bin_index) < 32'(NUM_BINS));
        end
    end

endmodule

// ===== rtl/core/phmm_back.sv =====
`timescale 1ns / 1ps
// Back of the histogram: bin memory update, read-out, clearing sweep,
// running statistics and the result register. Depends on phmm_pkg, phmm_ram.
module phmm_back #(
    parameter int NUM_BINS   = phmm_pkg::NUM_BINS_DEF,
    parameter int PIXEL_BITS = phmm_pkg::PIXEL_BITS_DEF,
    parameter int COUNT_BITS = phmm_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  phmm_pkg::t_work     i_q_data,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    output logic                o_init_busy,
    output logic                o_empty,
    input  logic                i_pop,
    output phmm_pkg::t_out_item o_result
);

    import phmm_pkg::*;

    localparam int BIN_BITS = $clog2(NUM_BINS);
    localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(NUM_BINS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
    localparam logic [PIXEL_BITS-1:0] PIX_ONES  = {PIXEL_BITS{1'b1}};

    typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_ADD, S_READ} t_state;

    t_state                r_state,    n_state;
    logic [BIN_BITS-1:0]   r_clr_addr, n_clr_addr;
    logic                  r_init,     n_init;
    logic [PIXEL_BITS-1:0] r_min,      n_min;
    logic [PIXEL_BITS-1:0] r_max,      n_max;
    logic [COUNT_BITS-1:0] r_peak,     n_peak;
    t_work                 r_cur,      n_cur;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out,      n_out;

    logic                  ram_we;
    logic [BIN_BITS-1:0]   ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [BIN_BITS-1:0]   ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [PIXEL_BITS-1:0] q_px;
    logic                  slot_free;

    phmm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign q_px      = PIXEL_BITS'(i_q_data.pixel);
    assign cnt_inc   = (ram_rdata == COUNT_TOP) ? ram_rdata : ram_rdata + 1'b1;
    assign slot_free = !r_out_valid || i_pop;
    assign ram_raddr = BIN_BITS'(i_q_data.bin);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_init      = r_init;
        n_min       = r_min;
        n_max       = r_max;
        n_peak      = r_peak;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = BIN_BITS'(r_cur.bin);
        ram_wdata   = cnt_inc;

        case (r_state)
            S_SWEEP: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_BIN) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_data;
                    case (i_q_data.op)
                        OP_ADD: begin
                            if (q_px < r_min) begin
                                n_min = q_px;
                            end
                            if (q_px > r_max) begin
                                n_max = q_px;
                            end
                            n_state = S_ADD;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        OP_CLEAR: begin
                            n_min                = PIX_ONES;
                            n_max                = '0;
                            n_peak               = '0;
                            n_clr_addr           = '0;
                            n_state              = S_SWEEP;
                            n_out_valid          = 1'b1;
                            n_out.bin_count      = '0;
                            n_out.min_pixel      = 16'(PIX_ONES);
                            n_out.max_pixel      = '0;
                            n_out.peak_count     = '0;
                        end
                        default: begin
                            // unused code: report the statistics unchanged
                            n_out_valid      = 1'b1;
                            n_out.bin_count  = '0;
                            n_out.min_pixel  = 16'(r_min);
                            n_out.max_pixel  = 16'(r_max);
                            n_out.peak_count = 24'(r_peak);
                        end
                    endcase
                end
            end
            S_ADD: begin
                ram_we = 1'b1;
                if (cnt_inc > r_peak) begin
                    n_peak = cnt_inc;
                end
                n_out_valid      = 1'b1;
                n_out.bin_count  = '0;
                n_out.min_pixel  = 16'(r_min);
                n_out.max_pixel  = 16'(r_max);
                n_out.peak_count = (cnt_inc > r_peak) ? 24'(cnt_inc) : 24'(r_peak);
                n_state          = S_IDLE;
            end
            S_READ: begin
                n_out_valid      = 1'b1;
                n_out.bin_count  = r_cur.in_range ? 24'(ram_rdata) : '0;
                n_out.min_pixel  = 16'(r_min);
                n_out.max_pixel  = 16'(r_max);
                n_out.peak_count = 24'(r_peak);
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_clr_addr  <= '0;
            r_init      <= 1'b1;
            r_min       <= PIX_ONES;
            r_max       <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_init      <= n_init;
            r_min       <= n_min;
            r_max       <= n_max;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
        end
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_init_busy = r_init;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== rtl/core/pixel_histogram_min_max_top.sv =====
`timescale 1ns / 1ps
// Top level of the pixel histogram with running min, max and peak count.
// Depends on phmm_pkg, phmm_front, phmm_queue, phmm_back.
//
//   Channel   Handshake          Payload             Direction
//   -------   ----------------   -----------------   ---------
//   input     push / full        i_item   t_in_item  in
//   result    empty / pop        o_result t_out_item out
//
// In the back an add reads its bin, then writes it back; a read reads its bin, then
// returns it; an unused code reports from idle; a clear reports, then sweeps the bin RAM.
// The front registers each item, and a four-entry queue decouples it from the back.
// After reset full stays high while the bin RAM is zeroed. A result waits in the output
// register and holds the back until popped, so the queue can fill and raise full.
module pixel_histogram_min_max_top #(
    parameter int NUM_BINS   = phmm_pkg::NUM_BINS_DEF,
    parameter int PIXEL_BITS = phmm_pkg::PIXEL_BITS_DEF,
    parameter int COUNT_BITS = phmm_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  phmm_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output phmm_pkg::t_out_item o_result
);

    import phmm_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_work q_wr_data;
    t_work q_rd_data;
    logic  init_busy;

    phmm_front #(
        .NUM_BINS   (NUM_BINS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_hold   (init_busy),
        .o_q_push (q_push),
        .o_q_data (q_wr_data),
        .i_q_full (q_full)
    );

    phmm_queue #(
        .WIDTH ($bits(t_work)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    phmm_back #(
        .NUM_BINS   (NUM_BINS),
        .PIXEL_BITS (PIXEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rd_data),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

    // No transaction may enter while the bin RAM is being zeroed after reset
    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> full)
        else $error("input accepted during the reset sweep");

    // During the reset sweep nothing is queued and no result is pending
    a_init_nothing_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> (q_empty && empty))
        else $error("work pending during the reset sweep");

    // Reset always starts the sweep of the bin RAM
    a_reset_starts_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> init_busy)
        else $error("reset did not start the bin RAM sweep");

endmodule

// ===== tb/sv/pixel_histogram_min_max_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pixel_histogram_min_max_top: a histogram mirror
// predicts the statistics of every transaction. Depends on phmm_pkg and the RTL.
module pixel_histogram_min_max_top_test;
    import phmm_pkg::*;

    localparam int NBINS = NUM_BINS_DEF;
    localparam int PIX_W = PIXEL_BITS_DEF;
    localparam int CNT_W = COUNT_BITS_DEF;
    localparam longint unsigned PIX_ONES = (64'd1 << PIX_W) - 64'd1;
    localparam t_op OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 650;
    localparam int CYCLE_LIMIT = 400000;

    // Mirror of the bins and running statistics, with the results still owed
    class histogram_mirror;
        logic [CNT_W-1:0] bin_cnt [NBINS];
        logic [PIX_W-1:0] run_min;
        logic [PIX_W-1:0] run_max;
        logic [CNT_W-1:0] peak;
        logic [CNT_W-1:0] best_peak;
        t_out_item owed_stats[$];
        int errors;
        int checked;

        function new();
            wipe();
            best_peak = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void wipe();
            foreach (bin_cnt[i]) bin_cnt[i] = '0;
            run_min = PIX_ONES[PIX_W-1:0];
            run_max = '0;
            peak = '0;
        endfunction

        function void record_item(t_in_item it);
            t_out_item stats;
            longint unsigned prod;
            int unsigned bin;
            stats = '0;
            case (it.operation)
                OP_ADD: begin
                    prod = 64'(it.pixel) * 64'(NBINS - 1);
                    bin = int'(prod / PIX_ONES);
                    if (bin >= NBINS) bin = NBINS - 1;
                    if (it.pixel < run_min) run_min = it.pixel;
                    if (it.pixel > run_max) run_max = it.pixel;
                    // hold at the top value once saturated
                    if (bin_cnt[bin] != {CNT_W{1'b1}}) bin_cnt[bin] = bin_cnt[bin] + 1'b1;
                    if (bin_cnt[bin] > peak) peak = bin_cnt[bin];
                    if (peak > best_peak) best_peak = peak;
                end
                OP_READ: stats.bin_count = bin_cnt[it.bin_index];
                OP_CLEAR: wipe();
                default: ;
            endcase
            stats.min_pixel = run_min;
            stats.max_pixel = run_max;
            stats.peak_count = peak;
            owed_stats.push_back(stats);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(t_out_item got);
            t_out_item want;
            if (owed_stats.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = owed_stats.pop_front();
            checked++;
            check_field("bin_count", 32'(want.bin_count), 32'(got.bin_count));
            check_field("min_pixel", 32'(want.min_pixel), 32'(got.min_pixel));
            check_field("max_pixel", 32'(want.max_pixel), 32'(got.max_pixel));
            check_field("peak_count", 32'(want.peak_count), 32'(got.peak_count));
        endfunction

        function void flag_leftovers();
            if (owed_stats.size() != 0) begin
                $display("%0t: missing results: expected %0d more, actual 0", $time,
                         owed_stats.size());
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_in_item i_item = '0;
    logic full;
    logic empty;
    t_out_item o_result;

    histogram_mirror mirror = new();
    int sent_count = 0;
    int n_add = 0;
    int n_read = 0;
    int n_clear = 0;
    int n_unused = 0;
    int cycles = 0;

    pixel_histogram_min_max_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[pixel_histogram_min_max_top] ERROR");
            $finish;
        end
    end

    function automatic t_in_item item_of(t_op op, logic [15:0] px, logic [9:0] idx);
        t_in_item it;
        it.operation = op;
        it.pixel = px;
        it.bin_index = idx;
        return it;
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(input t_in_item it);
        bit steady;
        steady = (sent_count >= 250 && sent_count < 400);
        while (!steady && $urandom_range(0, 99) < 12) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        mirror.record_item(it);
        case (it.operation)
            OP_ADD: n_add++;
            OP_READ: n_read++;
            OP_CLEAR: n_clear++;
            default: n_unused++;
        endcase
        if (it.operation != OP_UNUSED) sent_count++;
    endtask

    function automatic logic [15:0] near_pixel(int centre, int spread);
        int p;
        p = centre + $urandom_range(0, 2 * spread) - spread;
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
        return 16'(p);
    endfunction

    function automatic logic [9:0] near_bin(int centre);
        int b;
        b = (centre >> 6) + $urandom_range(0, 2) - 1;
        if (b < 0) b = 0;
        if (b > NBINS - 1) b = NBINS - 1;
        return 10'(b);
    endfunction

    task automatic random_traffic();
        int centre;
        int pick;
        int burst;
        logic [15:0] edges [7];
        edges = '{16'd0, 16'd1, 16'd64, 16'd65, 16'd65471, 16'd65534, 16'hFFFF};
        centre = $urandom_range(0, 65535);
        while (sent_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // burst of samples around one brightness, so some bins climb
                if ($urandom_range(0, 3) == 0) centre = $urandom_range(0, 65535);
                burst = $urandom_range(3, 12);
                repeat (burst)
                    send_item(item_of(OP_ADD, near_pixel(centre, 150), 10'($urandom)));
            end else if (pick < 80) begin
                if ($urandom_range(0, 9) < 7)
                    send_item(item_of(OP_READ, 16'($urandom), near_bin(centre)));
                else
                    send_item(item_of(OP_READ, 16'($urandom), 10'($urandom)));
            end else if (pick < 83) begin
                send_item(item_of(OP_CLEAR, 16'($urandom), 10'($urandom)));
            end else if (pick < 88) begin
                send_item(item_of(OP_UNUSED, 16'($urandom), 10'($urandom)));
            end else begin
                send_item(item_of(OP_ADD, edges[$urandom_range(0, 6)], 10'($urandom)));
            end
        end
    endtask

    initial begin : result_sink
        int hold_left;
        int pops;
        bit held;
        bit want;
        hold_left = 0;
        pops = 0;
        held = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                mirror.compare_result(o_result);
                pops++;
            end
            // stall the results long enough for the queue to fill and push back
            if (!held && sent_count >= 120) begin
                held = 1;
                hold_left = 90;
            end
            if (hold_left > 0) begin
                hold_left--;
                want = 1'b0;
            end else if (pops >= 300 && pops < 450) begin
                want = 1'b1;
            end else begin
                want = ($urandom_range(0, 99) >= 12);
            end
            pop <= want;
        end
    end

    initial begin : stimulus
        int drain;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bin edges, extreme pixels and the first sample after reset
        send_item(item_of(OP_ADD, 16'd40000, 10'd0));
        send_item(item_of(OP_ADD, 16'd0, 10'h3FF));
        send_item(item_of(OP_ADD, 16'hFFFF, 10'd0));
        send_item(item_of(OP_ADD, 16'd64, 10'd0));
        send_item(item_of(OP_ADD, 16'd65, 10'd0));
        send_item(item_of(OP_ADD, 16'd65534, 10'd0));
        send_item(item_of(OP_ADD, 16'd32768, 10'd0));
        send_item(item_of(OP_ADD, 16'd32768, 10'd0));
        send_item(item_of(OP_READ, 16'hFFFF, 10'd0));
        send_item(item_of(OP_READ, 16'd0, 10'h3FF));
        send_item(item_of(OP_READ, 16'd0, 10'd1022));
        send_item(item_of(OP_READ, 16'd0, 10'd511));
        send_item(item_of(OP_READ, 16'd0, 10'd1));
        send_item(item_of(OP_READ, 16'd0, 10'd5));
        send_item(item_of(OP_UNUSED, 16'hFFFF, 10'h3FF));
        send_item(item_of(OP_CLEAR, 16'hFFFF, 10'h3FF));
        send_item(item_of(OP_READ, 16'd0, 10'd0));
        send_item(item_of(OP_UNUSED, 16'd0, 10'd0));
        // a lone sample after clear must move both minimum and maximum
        send_item(item_of(OP_ADD, 16'd1000, 10'd0));
        send_item(item_of(OP_ADD, 16'd2000, 10'd0));
        send_item(item_of(OP_ADD, 16'd500, 10'd0));
        send_item(item_of(OP_READ, 16'd0, 10'd15));

        random_traffic();
        push <= 1'b0;

        drain = 0;
        while (mirror.owed_stats.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        mirror.flag_leftovers();

        $display("Sent %0d adds, %0d reads, %0d clears, %0d unused codes; %0d results checked.",
                 n_add, n_read, n_clear, n_unused, mirror.checked);
        $display("Highest bin count seen: %0d, with one long result stall.", mirror.best_peak);
        if (mirror.errors == 0) begin
            $display("[pixel_histogram_min_max_top] OK");
        end else begin
            $display("[pixel_histogram_min_max_top] ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/phmm_pkg.sv
rtl/core/phmm_ram.sv
rtl/core/phmm_queue.sv
rtl/core/phmm_front.sv
rtl/core/phmm_back.sv
rtl/core/pixel_histogram_min_max_top.sv
tb/sv/pixel_histogram_min_max_top_test.sv
